// ===== rtl/core/lbi_pkg.sv =====
// Shared types and constants for the LUT bilinear interpolator.
// Holds operation codes, status codes, command kinds and the queued command.
// No dependencies.
package lbi_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int ARC_W    = 4;
    localparam int POS_W    = 3;
    localparam int CNT_W    = 4;
    localparam int STATUS_W = 2;
    localparam int KIND_W   = 3;

    // Operation codes on the request channel
    localparam logic [OP_W-1:0] OP_QUERY    = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_X     = 3'd1;
    localparam logic [OP_W-1:0] OP_WR_Y     = 3'd2;
    localparam logic [OP_W-1:0] OP_WR_RISE  = 3'd3;
    localparam logic [OP_W-1:0] OP_WR_FALL  = 3'd4;

    // Status codes on the response channel
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_X_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_Y_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIV0    = 2'd3;

    // Configuration register indexes
    localparam logic CFG_X_POINTS = 1'b0;
    localparam logic CFG_Y_POINTS = 1'b1;

    // Command kinds after classification
    localparam logic [KIND_W-1:0] KIND_NOP     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WR_X    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WR_Y    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WR_RISE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_WR_FALL = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [ARC_W-1:0]         arc;
        logic [POS_W-1:0]         row;
        logic [POS_W-1:0]         col;
        logic signed [DATA_W-1:0] write_value;
        logic signed [DATA_W-1:0] x_query;
        logic signed [DATA_W-1:0] y_query;
        logic                     rising;
        logic                     allow_extrapolate;
    } lbi_cmd_t;

endpackage

// ===== rtl/core/lbi_if.sv =====
// Request and response channel interfaces for the LUT bilinear interpolator.
// Depends on lbi_pkg for field widths.
interface lbi_req_if;
    logic                              valid;
    logic                              ready;
    logic [lbi_pkg::OP_W-1:0]          op;
    logic [lbi_pkg::ARC_W-1:0]         arc;
    logic [lbi_pkg::POS_W-1:0]         row;
    logic [lbi_pkg::POS_W-1:0]         col;
    logic signed [lbi_pkg::DATA_W-1:0] write_value;
    logic signed [lbi_pkg::DATA_W-1:0] x_query;
    logic signed [lbi_pkg::DATA_W-1:0] y_query;
    logic                              rising;
    logic                              allow_extrapolate;

    modport source (output valid, op, arc, row, col, write_value, x_query, y_query,
                    rising, allow_extrapolate, input ready);
    modport sink (input valid, op, arc, row, col, write_value, x_query, y_query,
                  rising, allow_extrapolate, output ready);
endinterface

interface lbi_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [lbi_pkg::DATA_W-1:0]   result;
    logic [lbi_pkg::STATUS_W-1:0]        status;

    modport source (output valid, result, status, input ready);
    modport sink (input valid, result, status, output ready);
endinterface

// ===== rtl/core/lbi_front.sv =====
// Front end: accepts request transactions and classifies them into commands.
// Depends on lbi_pkg and lbi_req_if.
module lbi_front #(
    parameter int ARCS      = 16,
    parameter int TABLE_DIM = 8
) (
    lbi_req_if.sink            req,
    input  logic               full,
    output logic               push,
    output lbi_pkg::lbi_cmd_t  push_cmd
);

    localparam int ARC_VALS = 1 << lbi_pkg::ARC_W;

    logic [lbi_pkg::ARC_W-1:0] arc_mod [ARC_VALS];
    logic                      row_ok;
    logic                      col_ok;

    // Fold the arc number onto the configured arc count
    for (genvar a = 0; a < ARC_VALS; a++) begin : g_arc_mod
        assign arc_mod[a] = lbi_pkg::ARC_W'(a % ARCS);
    end

    assign req.ready = !full;
    assign push      = req.valid && !full;

    assign row_ok = 32'(req.row) < TABLE_DIM;
    assign col_ok = 32'(req.col) < TABLE_DIM;

    // Classify the operation; drop writes to positions outside the table
    always_comb
    begin
        push_cmd.arc               = arc_mod[req.arc];
        push_cmd.row               = req.row;
        push_cmd.col               = req.col;
        push_cmd.write_value       = req.write_value;
        push_cmd.x_query           = req.x_query;
        push_cmd.y_query           = req.y_query;
        push_cmd.rising            = req.rising;
        push_cmd.allow_extrapolate = req.allow_extrapolate;
        unique case (req.op)
            lbi_pkg::OP_QUERY:   push_cmd.kind = lbi_pkg::KIND_QUERY;
            lbi_pkg::OP_WR_X:    push_cmd.kind = row_ok ? lbi_pkg::KIND_WR_X : lbi_pkg::KIND_NOP;
            lbi_pkg::OP_WR_Y:    push_cmd.kind = row_ok ? lbi_pkg::KIND_WR_Y : lbi_pkg::KIND_NOP;
            lbi_pkg::OP_WR_RISE: push_cmd.kind = (row_ok && col_ok) ? lbi_pkg::KIND_WR_RISE
                                                                    : lbi_pkg::KIND_NOP;
            lbi_pkg::OP_WR_FALL: push_cmd.kind = (row_ok && col_ok) ? lbi_pkg::KIND_WR_FALL
                                                                    : lbi_pkg::KIND_NOP;
            default:             push_cmd.kind = lbi_pkg::KIND_NOP;
        endcase
    end

endmodule

// ===== rtl/core/lbi_fifo.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on lbi_pkg for the command type.
module lbi_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lbi_pkg::lbi_cmd_t  push_cmd,
    output logic               full,
    input  logic               pop,
    output logic               pop_valid,
    output lbi_pkg::lbi_cmd_t  pop_cmd
);

    lbi_pkg::lbi_cmd_t entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    assign full      = count_reg == 2'd2;
    assign pop_valid = count_reg != 2'd0;
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && pop_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop && pop_valid})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/core/lbi_lerp.sv =====
// Shared linear interpolation unit: za + (zb - za) * (v - a) / (b - a).
// Split multiply, bit-per-cycle restoring division, saturation. Uses no package.
module lbi_lerp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] v,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    input  logic signed [31:0] za,
    input  logic signed [31:0] zb,
    output logic               done,
    output logic signed [31:0] y
);

    localparam logic [3:0] L_IDLE = 4'd0;
    localparam logic [3:0] L_ABS  = 4'd1;
    localparam logic [3:0] L_MUL  = 4'd2;
    localparam logic [3:0] L_ADD  = 4'd3;
    localparam logic [3:0] L_CHK  = 4'd4;
    localparam logic [3:0] L_DIV  = 4'd5;
    localparam logic [3:0] L_CAP  = 4'd6;
    localparam logic [3:0] L_NEG  = 4'd7;
    localparam logic [3:0] L_SUM  = 4'd8;

    localparam logic [40:0]        Q_CAP  = 41'd1 << 40;
    localparam logic signed [42:0] SAT_HI = 43'sd2147483647;
    localparam logic signed [42:0] SAT_LO = -43'sd2147483648;

    logic [3:0]         state_reg;
    logic signed [32:0] dz_reg;
    logic signed [32:0] dv_reg;
    logic signed [32:0] db_reg;
    logic signed [31:0] za_reg;
    logic               neg_reg;
    logic [32:0]        mz_reg;
    logic [32:0]        mv_reg;
    logic [32:0]        mb_reg;
    logic [49:0]        pp0_reg;
    logic [48:0]        pp1_reg;
    logic [65:0]        prod_reg;
    logic [32:0]        rem_reg;
    logic [40:0]        low_reg;
    logic [40:0]        q_reg;
    logic [5:0]         cnt_reg;
    logic signed [41:0] sq_reg;
    logic               done_reg;
    logic signed [31:0] y_reg;

    logic [33:0]        trial;
    logic               trial_ge;
    logic signed [42:0] sum;

    assign trial    = {rem_reg, low_reg[40]};
    assign trial_ge = trial >= {1'b0, mb_reg};
    assign sum      = {{11{za_reg[31]}}, za_reg} + {sq_reg[41], sq_reg};

    assign done = done_reg;
    assign y    = y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= L_ABS;
                    end
                end
                L_ABS:   state_reg <= L_MUL;
                L_MUL:   state_reg <= L_ADD;
                L_ADD:   state_reg <= L_CHK;
                L_CHK:
                begin
                    if ({8'd0, prod_reg} >= {mb_reg, 41'd0})
                    begin
                        state_reg <= L_NEG;
                    end
                    else
                    begin
                        state_reg <= L_DIV;
                    end
                end
                L_DIV:
                begin
                    if (cnt_reg == 6'd40)
                    begin
                        state_reg <= L_CAP;
                    end
                end
                L_CAP:   state_reg <= L_NEG;
                L_NEG:   state_reg <= L_SUM;
                L_SUM:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= L_IDLE;
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            L_IDLE:
            begin
                dz_reg <= {zb[31], zb} - {za[31], za};
                dv_reg <= {v[31], v} - {a[31], a};
                db_reg <= {b[31], b} - {a[31], a};
                za_reg <= za;
            end
            L_ABS:
            begin
                neg_reg <= dz_reg[32] ^ dv_reg[32] ^ db_reg[32];
                mz_reg  <= dz_reg[32] ? 33'(-dz_reg) : 33'(dz_reg);
                mv_reg  <= dv_reg[32] ? 33'(-dv_reg) : 33'(dv_reg);
                mb_reg  <= db_reg[32] ? 33'(-db_reg) : 33'(db_reg);
            end
            L_MUL:
            begin
                pp0_reg <= mz_reg * mv_reg[16:0];
                pp1_reg <= mz_reg * mv_reg[32:17];
            end
            L_ADD:
            begin
                prod_reg <= 66'(pp0_reg) + (66'(pp1_reg) << 17);
            end
            L_CHK:
            begin
                // quotient of 2^41 or more saturates at once
                q_reg   <= Q_CAP;
                rem_reg <= 33'(prod_reg[65:41]);
                low_reg <= prod_reg[40:0];
                cnt_reg <= 6'd0;
                if ({8'd0, prod_reg} < {mb_reg, 41'd0})
                begin
                    q_reg <= 41'd0;
                end
            end
            L_DIV:
            begin
                rem_reg <= trial_ge ? 33'(trial - {1'b0, mb_reg}) : 33'(trial);
                q_reg   <= {q_reg[39:0], trial_ge};
                low_reg <= low_reg << 1;
                cnt_reg <= cnt_reg + 6'd1;
            end
            L_CAP:
            begin
                if (q_reg > Q_CAP)
                begin
                    q_reg <= Q_CAP;
                end
            end
            L_NEG:
            begin
                sq_reg <= neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
            end
            L_SUM:
            begin
                if (sum > SAT_HI)
                begin
                    y_reg <= 32'sh7FFFFFFF;
                end
                else if (sum < SAT_LO)
                begin
                    y_reg <= 32'sh80000000;
                end
                else
                begin
                    y_reg <= sum[31:0];
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/core/lbi_back.sv =====
// Back end: table memories, segment search sequencer and response register.
// Depends on lbi_pkg, lbi_rsp_if and lbi_lerp.
module lbi_back #(
    parameter int ARCS      = 16,
    parameter int TABLE_DIM = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    input  lbi_pkg::lbi_cmd_t         cmd,
    output logic                      cmd_pop,
    input  logic [lbi_pkg::CNT_W-1:0] x_count,
    input  logic [lbi_pkg::CNT_W-1:0] y_count,
    lbi_rsp_if.source                 rsp
);

    localparam int PW       = $clog2(TABLE_DIM);
    localparam int BP_DEPTH = ARCS * TABLE_DIM;
    localparam int T_DEPTH  = BP_DEPTH * TABLE_DIM;
    localparam int BP_AW    = (BP_DEPTH > 1) ? $clog2(BP_DEPTH) : 1;
    localparam int T_AW     = $clog2(T_DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRD   = 4'd1;
    localparam logic [3:0] S_SCHK  = 4'd2;
    localparam logic [3:0] S_BP0   = 4'd3;
    localparam logic [3:0] S_BP1   = 4'd4;
    localparam logic [3:0] S_BP2   = 4'd5;
    localparam logic [3:0] S_TAB   = 4'd6;
    localparam logic [3:0] S_LERP  = 4'd7;
    localparam logic [3:0] S_LWAIT = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    function automatic logic [BP_AW-1:0] bp_addr(input logic [3:0] arc, input logic [3:0] pos);
        return BP_AW'(int'(arc) * TABLE_DIM + int'(pos));
    endfunction

    function automatic logic [T_AW-1:0] t_addr(input logic [3:0] arc, input logic [3:0] xp,
                                               input logic [3:0] yp);
        return T_AW'((int'(arc) * TABLE_DIM + int'(xp)) * TABLE_DIM + int'(yp));
    endfunction

    // Memories
    logic signed [31:0] x_mem    [BP_DEPTH];
    logic signed [31:0] y_mem    [BP_DEPTH];
    logic signed [31:0] rise_mem [T_DEPTH];
    logic signed [31:0] fall_mem [T_DEPTH];

    logic [BP_AW-1:0]   x_ra;
    logic [BP_AW-1:0]   y_ra;
    logic [T_AW-1:0]    t_ra;
    logic [BP_AW-1:0]   bp_wa;
    logic [T_AW-1:0]    t_wa;
    logic signed [31:0] x_rd_reg;
    logic signed [31:0] y_rd_reg;
    logic signed [31:0] rise_rd_reg;
    logic signed [31:0] fall_rd_reg;

    // Sequencer state
    logic [3:0]          state_reg;
    lbi_pkg::lbi_cmd_t   cur_reg;
    logic                axis_reg;
    logic [PW-1:0]       idx_reg;
    logic [PW-1:0]       xl_reg;
    logic [PW-1:0]       yl_reg;
    logic signed [31:0]  xa_reg;
    logic signed [31:0]  xb_reg;
    logic signed [31:0]  ya_reg;
    logic signed [31:0]  yb_reg;
    logic signed [31:0]  z_reg [4];
    logic signed [31:0]  zl_reg;
    logic signed [31:0]  zh_reg;
    logic [2:0]          tcnt_reg;
    logic [1:0]          lstep_reg;
    logic signed [31:0]  pend_res_reg;
    logic [1:0]          pend_st_reg;
    logic                rsp_valid_reg;
    logic signed [31:0]  rsp_result_reg;
    logic [1:0]          rsp_status_reg;

    // Search compare
    logic signed [31:0]  s_data;
    logic signed [31:0]  s_val;
    logic [3:0]          s_count;
    logic                s_gt;
    logic                s_last;

    // Interpolation unit hookup
    logic                lerp_start;
    logic signed [31:0]  l_v;
    logic signed [31:0]  l_a;
    logic signed [31:0]  l_b;
    logic signed [31:0]  l_za;
    logic signed [31:0]  l_zb;
    logic                lerp_done;
    logic signed [31:0]  lerp_y;

    assign cmd_pop = (state_reg == S_IDLE) && cmd_valid;

    assign bp_wa = bp_addr(cmd.arc, 4'(cmd.row));
    assign t_wa  = t_addr(cmd.arc, 4'(cmd.row), 4'(cmd.col));

    assign s_data  = axis_reg ? y_rd_reg : x_rd_reg;
    assign s_val   = axis_reg ? cur_reg.y_query : cur_reg.x_query;
    assign s_count = axis_reg ? y_count : x_count;
    assign s_gt    = s_data > s_val;
    assign s_last  = 5'(idx_reg) == (5'(s_count) - 5'd1);

    // Drive read addresses from the sequencer
    always_comb
    begin
        x_ra = bp_addr(cur_reg.arc, 4'(idx_reg));
        y_ra = bp_addr(cur_reg.arc, 4'(idx_reg));
        t_ra = t_addr(cur_reg.arc, 4'(xl_reg) + 4'(tcnt_reg[1]), 4'(yl_reg) + 4'(tcnt_reg[0]));
        unique case (state_reg)
            S_BP0:
            begin
                x_ra = bp_addr(cur_reg.arc, 4'(xl_reg));
                y_ra = bp_addr(cur_reg.arc, 4'(yl_reg));
            end
            S_BP1:
            begin
                x_ra = bp_addr(cur_reg.arc, 4'(xl_reg) + 4'd1);
                y_ra = bp_addr(cur_reg.arc, 4'(yl_reg) + 4'd1);
            end
            default:
            begin
            end
        endcase
    end

    // Breakpoint memories: write from the popped command, registered read
    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.kind == lbi_pkg::KIND_WR_X)
        begin
            x_mem[bp_wa] <= cmd.write_value;
        end
        if (cmd_pop && cmd.kind == lbi_pkg::KIND_WR_Y)
        begin
            y_mem[bp_wa] <= cmd.write_value;
        end
        x_rd_reg <= x_mem[x_ra];
        y_rd_reg <= y_mem[y_ra];
    end

    // Value table memories
    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.kind == lbi_pkg::KIND_WR_RISE)
        begin
            rise_mem[t_wa] <= cmd.write_value;
        end
        if (cmd_pop && cmd.kind == lbi_pkg::KIND_WR_FALL)
        begin
            fall_mem[t_wa] <= cmd.write_value;
        end
        rise_rd_reg <= rise_mem[t_ra];
        fall_rd_reg <= fall_mem[t_ra];
    end

    // Pick operands for each of the three interpolations
    always_comb
    begin
        lerp_start = state_reg == S_LERP;
        l_v  = cur_reg.y_query;
        l_a  = ya_reg;
        l_b  = yb_reg;
        l_za = z_reg[0];
        l_zb = z_reg[1];
        case (lstep_reg)
            2'd1:
            begin
                l_za = z_reg[2];
                l_zb = z_reg[3];
            end
            2'd2:
            begin
                l_v  = cur_reg.x_query;
                l_a  = xa_reg;
                l_b  = xb_reg;
                l_za = zl_reg;
                l_zb = zh_reg;
            end
            default:
            begin
            end
        endcase
    end

    lbi_lerp u_lerp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lerp_start),
        .v     (l_v),
        .a     (l_a),
        .b     (l_b),
        .za    (l_za),
        .zb    (l_zb),
        .done  (lerp_done),
        .y     (lerp_y)
    );

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        if (cmd.kind == lbi_pkg::KIND_QUERY)
                        begin
                            state_reg <= S_SRD;
                        end
                        else
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_SRD:   state_reg <= S_SCHK;
                S_SCHK:
                begin
                    if (s_gt)
                    begin
                        if (idx_reg == '0 && !cur_reg.allow_extrapolate)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= axis_reg ? S_BP0 : S_SRD;
                        end
                    end
                    else if (s_last)
                    begin
                        if (s_data != s_val && !cur_reg.allow_extrapolate)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= axis_reg ? S_BP0 : S_SRD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SRD;
                    end
                end
                S_BP0:   state_reg <= S_BP1;
                S_BP1:   state_reg <= S_BP2;
                S_BP2:
                begin
                    if (xa_reg == x_rd_reg || ya_reg == y_rd_reg)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_TAB;
                    end
                end
                S_TAB:
                begin
                    if (tcnt_reg == 3'd4)
                    begin
                        state_reg <= S_LERP;
                    end
                end
                S_LERP:  state_reg <= S_LWAIT;
                S_LWAIT:
                begin
                    if (lerp_done)
                    begin
                        state_reg <= (lstep_reg == 2'd2) ? S_EMIT : S_LERP;
                    end
                end
                S_EMIT:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Sequencer datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cur_reg      <= cmd;
                axis_reg     <= 1'b0;
                idx_reg      <= '0;
                pend_res_reg <= '0;
                pend_st_reg  <= lbi_pkg::ST_OK;
            end
            S_SCHK:
            begin
                idx_reg <= idx_reg + PW'(1);
                if (s_gt || s_last)
                begin
                    // segment found or range error on this axis
                    idx_reg  <= '0;
                    axis_reg <= 1'b1;
                    if (s_gt)
                    begin
                        if (idx_reg == '0)
                        begin
                            xl_reg <= axis_reg ? xl_reg : '0;
                            yl_reg <= '0;
                        end
                        else
                        begin
                            xl_reg <= axis_reg ? xl_reg : idx_reg - PW'(1);
                            yl_reg <= idx_reg - PW'(1);
                        end
                    end
                    else
                    begin
                        xl_reg <= axis_reg ? xl_reg : PW'(s_count - 4'd2);
                        yl_reg <= PW'(s_count - 4'd2);
                    end
                    pend_st_reg <= axis_reg ? lbi_pkg::ST_Y_RANGE : lbi_pkg::ST_X_RANGE;
                end
            end
            S_BP1:
            begin
                xa_reg <= x_rd_reg;
                ya_reg <= y_rd_reg;
            end
            S_BP2:
            begin
                xb_reg      <= x_rd_reg;
                yb_reg      <= y_rd_reg;
                tcnt_reg    <= 3'd0;
                pend_st_reg <= lbi_pkg::ST_DIV0;
            end
            S_TAB:
            begin
                if (tcnt_reg != 3'd0)
                begin
                    z_reg[2'(tcnt_reg - 3'd1)] <= cur_reg.rising ? rise_rd_reg : fall_rd_reg;
                end
                tcnt_reg  <= tcnt_reg + 3'd1;
                lstep_reg <= 2'd0;
            end
            S_LWAIT:
            begin
                if (lerp_done)
                begin
                    lstep_reg <= lstep_reg + 2'd1;
                    case (lstep_reg)
                        2'd0:    zl_reg <= lerp_y;
                        2'd1:    zh_reg <= lerp_y;
                        default:
                        begin
                            pend_res_reg <= lerp_y;
                            pend_st_reg  <= lbi_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_result_reg <= (pend_st_reg == lbi_pkg::ST_OK) ? pend_res_reg : '0;
                    rsp_status_reg <= pend_st_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.result = rsp_result_reg;
    assign rsp.status = rsp_status_reg;

endmodule

// ===== rtl/core/lut_bilinear_interpolator.sv =====
// Bilinear lookup table interpolator with one breakpoint and table set per arc.
// Channels: req (command in), rsp (one response per command out). Valid/ready
// handshakes; a transaction completes when valid and ready are both high.
// Write commands (op 1..4) store a breakpoint or a rise/fall entry and answer
// result 0, status 0. A query finds the x and y segments, reads the four
// corner entries and interpolates along y twice, then along x.
// A write goes straight to its response. A query searches the breakpoints
// on each axis, fetches its operands, and makes 3 passes of the
// interpolation unit, whose restoring divider retires one quotient bit
// per cycle. A pass whose quotient saturates skips the divider; a range
// error answers right after the search. One command is processed at a time;
// a two-entry queue keeps accepting requests meanwhile.
// The response sits in an output register; while rsp is stalled the back end
// holds its next result and the queue fills, then req.ready drops.
// Reset clears the handshake state and sets x_points and y_points to 8.
// Table memories are not cleared; entries must be written before use.
// Depends on lbi_pkg, lbi_if, lbi_front, lbi_fifo, lbi_back.
module lut_bilinear_interpolator #(
    parameter int ARCS      = 16,
    parameter int TABLE_DIM = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_wdata,
    lbi_req_if.sink     req,
    lbi_rsp_if.source   rsp
);

    logic [lbi_pkg::CNT_W-1:0] x_points_reg;
    logic [lbi_pkg::CNT_W-1:0] y_points_reg;
    logic [lbi_pkg::CNT_W-1:0] x_count;
    logic [lbi_pkg::CNT_W-1:0] y_count;

    logic               push;
    logic               full;
    lbi_pkg::lbi_cmd_t  push_cmd;
    logic               pop;
    logic               pop_valid;
    lbi_pkg::lbi_cmd_t  pop_cmd;

    function automatic logic [lbi_pkg::CNT_W-1:0] clamp_count(
        input logic [lbi_pkg::CNT_W-1:0] n);
        if (n < 4'd2)
        begin
            return 4'd2;
        end
        if (5'(n) > 5'(TABLE_DIM))
        begin
            return lbi_pkg::CNT_W'(TABLE_DIM);
        end
        return n;
    endfunction

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_points_reg <= 4'd8;
            y_points_reg <= 4'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lbi_pkg::CFG_X_POINTS: x_points_reg <= cfg_wdata;
                lbi_pkg::CFG_Y_POINTS: y_points_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign x_count = clamp_count(x_points_reg);
    assign y_count = clamp_count(y_points_reg);

    lbi_front #(
        .ARCS      (ARCS),
        .TABLE_DIM (TABLE_DIM)
    ) u_front (
        .req      (req),
        .full     (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    lbi_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd)
    );

    lbi_back #(
        .ARCS      (ARCS),
        .TABLE_DIM (TABLE_DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd       (pop_cmd),
        .cmd_pop   (pop),
        .x_count   (x_count),
        .y_count   (y_count),
        .rsp       (rsp)
    );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the LUT bilinear interpolator: directed and random
// commands against an in-house predictor of breakpoint search and interpolation.
// Depends on lbi_pkg, lbi_if and lut_bilinear_interpolator.
module testbench;

    localparam int ARCS = 16;
    localparam int DIM  = 8;

    typedef struct {
        logic signed [31:0] result;
        logic [1:0]         status;
    } lut_resp_t;

    // Expected responses in order, plus the count of mismatches
    class lut_scoreboard;
        lut_resp_t pending[$];
        int        errors;
        int        matched;

        function void note_command(lut_resp_t r);
            pending.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_response(logic signed [31:0] res, logic [1:0] st);
            lut_resp_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("response with none expected (%0d, %0d)", res, st));
                return;
            end
            e = pending.pop_front();
            matched++;
            if (e.result !== res || e.status !== st)
            begin
                report($sformatf("result %0d status %0d, expected %0d status %0d",
                                 res, st, e.result, e.status));
            end
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [3:0] cfg_wdata;

    lbi_req_if req ();
    lbi_rsp_if rsp ();

    lut_bilinear_interpolator #(.ARCS(ARCS), .TABLE_DIM(DIM)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .req(req), .rsp(rsp)
    );

    lut_scoreboard sb;

    // Predictor state
    logic signed [31:0] xbp [ARCS*DIM];
    logic signed [31:0] ybp [ARCS*DIM];
    logic signed [31:0] rise_tab [ARCS*DIM*DIM];
    logic signed [31:0] fall_tab [ARCS*DIM*DIM];
    logic [3:0]         x_count;
    logic [3:0]         y_count;

    int send_idle;
    int recv_idle;
    int queries;
    int query_errs;

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int clamp_points(logic [3:0] n);
        if (n < 2) return 2;
        if (n > DIM) return DIM;
        return int'(n);
    endfunction

    // Linear step with exact product, truncation toward zero, 2^40 quotient cap
    function automatic logic signed [31:0] lerp_step(longint v, longint a, longint b,
                                                     longint za, longint zb);
        longint dz, dv, db, q, s;
        logic [127:0] prod;
        logic [127:0] quo;
        bit neg;
        dz = zb - za;
        dv = v - a;
        db = b - a;
        neg = (dz < 0) ^ (dv < 0) ^ (db < 0);
        prod = 128'(dz < 0 ? -dz : dz) * 128'(dv < 0 ? -dv : dv);
        quo = prod / 128'(db < 0 ? -db : db);
        q = (quo > (128'd1 << 40)) ? (longint'(1) << 40) : longint'(quo);
        s = za + (neg ? -q : q);
        if (s > 64'sd2147483647) return 32'sh7fffffff;
        if (s < -64'sd2147483648) return 32'sh80000000;
        return s[31:0];
    endfunction

    // Lower segment index; -1 when out of range
    function automatic int find_lower(int base, bit is_x, int n, logic signed [31:0] v,
                                      bit ext);
        int i;
        logic signed [31:0] bp;
        i = 0;
        while (i < n)
        begin
            bp = is_x ? xbp[base + i] : ybp[base + i];
            if (bp > v) break;
            i++;
        end
        if (i == 0) return ext ? 0 : -1;
        if (i == n)
        begin
            bp = is_x ? xbp[base + n - 1] : ybp[base + n - 1];
            if (v != bp && !ext) return -1;
            return n - 2;
        end
        return i - 1;
    endfunction

    function automatic lut_resp_t predict_lookup(logic [2:0] op, logic [3:0] arc,
            logic [2:0] row, logic [2:0] col, logic signed [31:0] wv,
            logic signed [31:0] xq, logic signed [31:0] yq, bit rising, bit ext);
        lut_resp_t r;
        int xl, yl, b, t;
        logic signed [31:0] z00, z01, z10, z11, zl, zh;
        r.result = 0;
        r.status = lbi_pkg::ST_OK;
        b = arc * DIM;
        t = arc * DIM * DIM;
        case (op)
            lbi_pkg::OP_WR_X: xbp[b + row] = wv;
            lbi_pkg::OP_WR_Y: ybp[b + row] = wv;
            lbi_pkg::OP_WR_RISE: rise_tab[t + row*DIM + col] = wv;
            lbi_pkg::OP_WR_FALL: fall_tab[t + row*DIM + col] = wv;
            lbi_pkg::OP_QUERY:
            begin
                xl = find_lower(b, 1, clamp_points(x_count), xq, ext);
                yl = (xl < 0) ? -1 : find_lower(b, 0, clamp_points(y_count), yq, ext);
                if (xl < 0) r.status = lbi_pkg::ST_X_RANGE;
                else if (yl < 0) r.status = lbi_pkg::ST_Y_RANGE;
                else if (xbp[b+xl] == xbp[b+xl+1] || ybp[b+yl] == ybp[b+yl+1])
                    r.status = lbi_pkg::ST_DIV0;
                else
                begin
                    z00 = rising ? rise_tab[t + xl*DIM + yl] : fall_tab[t + xl*DIM + yl];
                    z01 = rising ? rise_tab[t + xl*DIM + yl+1]
                                 : fall_tab[t + xl*DIM + yl+1];
                    z10 = rising ? rise_tab[t + (xl+1)*DIM + yl]
                                 : fall_tab[t + (xl+1)*DIM + yl];
                    z11 = rising ? rise_tab[t + (xl+1)*DIM + yl+1]
                                 : fall_tab[t + (xl+1)*DIM + yl+1];
                    zl = lerp_step(yq, ybp[b+yl], ybp[b+yl+1], z00, z01);
                    zh = lerp_step(yq, ybp[b+yl], ybp[b+yl+1], z10, z11);
                    r.result = lerp_step(xq, xbp[b+xl], xbp[b+xl+1], zl, zh);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Drive one command and note its expected response on acceptance
    task automatic send_command(logic [2:0] op, logic [3:0] arc, logic [2:0] row,
            logic [2:0] col, logic signed [31:0] wv, logic signed [31:0] xq,
            logic signed [31:0] yq, bit rising, bit ext);
        lut_resp_t e;
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 0;
            @(posedge clk);
        end
        req.valid <= 1;
        req.op <= op;
        req.arc <= arc;
        req.row <= row;
        req.col <= col;
        req.write_value <= wv;
        req.x_query <= xq;
        req.y_query <= yq;
        req.rising <= rising;
        req.allow_extrapolate <= ext;
        do @(posedge clk); while (!req.ready);
        e = predict_lookup(op, arc, row, col, wv, xq, yq, rising, ext);
        if (op == lbi_pkg::OP_QUERY)
        begin
            queries++;
            if (e.status != lbi_pkg::ST_OK) query_errs++;
        end
        sb.note_command(e);
    endtask

    // Sample responses and stall at random
    initial
    begin
        rsp.ready = 0;
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready) sb.check_response(rsp.result, rsp.status);
            rsp.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Drop valid and wait for every outstanding response
    task automatic drain;
        int guard;
        guard = 0;
        req.valid <= 0;
        while (sb.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_config(logic idx, logic [3:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
        if (idx == lbi_pkg::CFG_X_POINTS) x_count = val; else y_count = val;
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(2000)) - 1000;
            2: return ($urandom_range(1)) ? 32'sh7fffffff - $urandom_range(3)
                                          : 32'sh80000000 + $urandom_range(3);
            default: return $signed($urandom_range(20'hfffff)) - 20'sh80000;
        endcase
    endfunction

    // Fill one arc: ascending breakpoints (some repeated) and both tables
    task automatic fill_arc(logic [3:0] arc, bit dup, bit wide);
        logic signed [31:0] v;
        int i, j, stepw;
        stepw = wide ? 32'h0fff_ffff : 32'h0002_0000;
        v = wide ? 32'sh90000000 : -$signed($urandom_range(32'h80000));
        for (i = 0; i < DIM; i++)
        begin
            send_command(lbi_pkg::OP_WR_X, arc, 3'(i), 0, v, 0, 0, 0, 0);
            v = v + ((dup && i == 2) ? 0 : $urandom_range(stepw, 1));
        end
        v = wide ? 32'sh90000000 : -$signed($urandom_range(32'h80000));
        for (i = 0; i < DIM; i++)
        begin
            send_command(lbi_pkg::OP_WR_Y, arc, 3'(i), 0, v, 0, 0, 0, 0);
            v = v + $urandom_range(stepw, 1);
        end
        for (i = 0; i < DIM; i++)
            for (j = 0; j < DIM; j++)
            begin
                send_command(lbi_pkg::OP_WR_RISE, arc, 3'(i), 3'(j), rand_word(), 0, 0, 0, 0);
                send_command(lbi_pkg::OP_WR_FALL, arc, 3'(i), 3'(j), rand_word(), 0, 0, 0, 0);
            end
    endtask

    // Coordinate near a breakpoint, at one, or anywhere
    function automatic logic signed [31:0] pick_coord(logic [3:0] arc, bit is_x);
        logic signed [31:0] bp;
        bp = is_x ? xbp[arc*DIM + $urandom_range(DIM-1)] : ybp[arc*DIM + $urandom_range(DIM-1)];
        case ($urandom_range(5))
            0: return bp;
            1: return $urandom;
            default: return bp + $signed($urandom_range(32'h40000)) - 32'sh20000;
        endcase
    endfunction

    task automatic random_query(int n_arcs);
        logic [3:0] arc;
        arc = 4'($urandom_range(n_arcs - 1));
        send_command(lbi_pkg::OP_QUERY, arc, 3'($urandom), 3'($urandom), $urandom,
                     pick_coord(arc, 1), pick_coord(arc, 0), 1'($urandom),
                     $urandom_range(3) != 0);
    endtask

    initial
    begin
        int k, phase;
        sb = new();
        send_idle = 18;
        recv_idle = 55;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_wdata = 0;
        req.valid = 0;
        req.op = 0;
        req.arc = 0;
        req.row = 0;
        req.col = 0;
        req.write_value = 0;
        req.x_query = 0;
        req.y_query = 0;
        req.rising = 0;
        req.allow_extrapolate = 0;
        x_count = 8;
        y_count = 8;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Arc 0 with a repeated x breakpoint, arc 1 wide-range to force saturation
        fill_arc(0, 1, 0);
        fill_arc(1, 0, 1);

        // Directed: endpoints, out of range on each axis, extrapolation, unused ops
        send_command(lbi_pkg::OP_QUERY, 0, 0, 0, 0, xbp[0], ybp[0], 1, 0);
        send_command(lbi_pkg::OP_QUERY, 0, 0, 0, 0, xbp[7], ybp[7], 0, 0);
        send_command(lbi_pkg::OP_QUERY, 0, 0, 0, 0, xbp[0] - 1, ybp[0], 1, 0);
        send_command(lbi_pkg::OP_QUERY, 0, 0, 0, 0, xbp[7] + 1, ybp[0] - 1, 1, 0);
        send_command(lbi_pkg::OP_QUERY, 0, 0, 0, 0, xbp[0], ybp[7] + 1, 1, 0);
        send_command(lbi_pkg::OP_QUERY, 0, 0, 0, 0, xbp[2], ybp[3], 1, 0);
        send_command(lbi_pkg::OP_QUERY, 0, 0, 0, 0, 32'sh80000000, 32'sh7fffffff, 0, 1);
        send_command(lbi_pkg::OP_QUERY, 0, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 1, 1);
        send_command(lbi_pkg::OP_QUERY, 1, 0, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 1, 1);
        send_command(lbi_pkg::OP_QUERY, 1, 0, 0, 0, 32'sh80000000, 32'sh80000000, 0, 1);
        send_command(lbi_pkg::OP_QUERY, 1, 7, 7, 32'hffffffff, xbp[DIM+3] + 5, ybp[DIM+4],
                     0, 0);
        for (k = 5; k < 8; k++)
            send_command(3'(k), 4'hf, 7, 7, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 1);
        drain();

        // Random phases over point-count settings on the filled arcs, each idling mode
        for (phase = 0; phase < 6; phase++)
        begin
            if (phase == 2) begin send_idle = 55; recv_idle = 18; end
            if (phase == 4) begin send_idle = 0;  recv_idle = 0;  end
            write_config(lbi_pkg::CFG_X_POINTS,
                         phase == 0 ? 4'd2 : phase == 5 ? 4'd15 : 4'($urandom_range(15)));
            write_config(lbi_pkg::CFG_Y_POINTS,
                         phase == 1 ? 4'd0 : phase == 3 ? 4'd8 : 4'($urandom_range(15)));
            for (k = 0; k < 25; k++) random_query(2);
            drain();
        end

        $display("covered %0d queries (%0d with error status) and %0d responses",
                 queries, query_errs, sb.matched);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
